@@ rtl/cfm_pkg.sv @@
// Package for the 5x5 mirrored RGB convolution filter.
// Shared sizes, types, state and code constants, and the kernel weight table.
// No dependencies.
package cfm_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int RING_ROWS  = 8;
    localparam int KERNEL_N   = 5;
    localparam int TAPS       = KERNEL_N * KERNEL_N;

    localparam int RING_W     = $clog2(RING_ROWS);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W   = $clog2(MAX_HEIGHT + 1);
    localparam int ADDR_W     = RING_W + COL_W;
    localparam int IDX_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int PEND_W     = $clog2(2 * MAX_WIDTH + 4);
    localparam int TAP_W      = $clog2(KERNEL_N);

    localparam int CH_W       = 8;
    localparam int PIX_W      = 4 * CH_W;
    localparam int WT_W       = 10;
    localparam int SUM_W      = 19;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_WID_W  = 12;
    localparam int CFG_HGT_W  = 13;
    localparam int DIV_STEPS  = 8;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    localparam int RECIP_W     = 16;
    localparam int RECIP25     = 41944;
    localparam int SHIFT25     = 20;
    localparam int RECIP81     = 25891;
    localparam int SHIFT81     = 21;
    localparam int GAUSS_SHIFT = 8;
    localparam int CH_MAX      = 255;
    localparam int EDGE_CTR    = 220;
    localparam int ENH_CTR     = 476;

    localparam logic [MODE_W-1:0] MODE_BOX     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BART    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GAUSS   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EDGE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ENHANCE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE,
        ST_READ,
        ST_SUM,
        ST_QUOT
    } t_state;

    typedef logic [CH_W-1:0] t_chan;
    typedef t_chan [2:0] t_rgb;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef t_sum [2:0] t_acc;

    function automatic logic [MODE_W-1:0] mode_eff(input logic [MODE_W-1:0] mode);
        return (mode > MODE_ENHANCE) ? MODE_BOX : mode;
    endfunction

    function automatic logic [2:0] vec_tap(input logic [MODE_W-1:0] mode, input int idx);
        logic [2:0] v;
        v = 3'd1;
        if (mode == MODE_BART) begin
            case (idx)
                1, 3:    v = 3'd2;
                2:       v = 3'd3;
                default: v = 3'd1;
            endcase
        end else if (mode != MODE_BOX) begin
            case (idx)
                1, 3:    v = 3'd4;
                2:       v = 3'd6;
                default: v = 3'd1;
            endcase
        end
        return v;
    endfunction

    function automatic logic signed [WT_W-1:0] kernel_weight(input logic [MODE_W-1:0] mode,
                                                            input int row, input int col);
        logic [MODE_W-1:0]        m;
        logic [5:0]               prod;
        logic signed [WT_W-1:0]   w;
        m    = mode_eff(mode);
        prod = 6'(vec_tap(m, row)) * 6'(vec_tap(m, col));
        w    = $signed(WT_W'(prod));
        if (m == MODE_EDGE || m == MODE_ENHANCE) begin
            if (row == KERNEL_N / 2 && col == KERNEL_N / 2) begin
                w = (m == MODE_EDGE) ? $signed(WT_W'(EDGE_CTR)) : $signed(WT_W'(ENH_CTR));
            end else begin
                w = -$signed(WT_W'(prod));
            end
        end
        return w;
    endfunction

endpackage

@@ rtl/cfm_unpremul.sv @@
// One color lane of the un-premultiply unit: floor(c*255/alpha), clamped.
// Restoring divider, one quotient bit per step. Uses cfm_pkg.
module cfm_unpremul import cfm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_load,
    input  logic  i_step,
    input  t_chan i_chan,
    input  t_chan i_alpha,
    output t_chan o_value
);

    logic [CH_W-1:0]   r_rem;
    logic [CH_W-1:0]   r_low;
    logic [CH_W-1:0]   r_den;
    logic [CH_W-1:0]   r_quo;
    logic              r_zero;
    logic              r_sat;
    logic [2*CH_W-1:0] num;
    logic [CH_W:0]     trial;
    logic              fits;

    assign num   = {i_chan, {CH_W{1'b0}}} - (2*CH_W)'(i_chan);
    assign trial = {r_rem, r_low[CH_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= num[2*CH_W-1:CH_W];
            r_low  <= num[CH_W-1:0];
            r_den  <= i_alpha;
            r_zero <= (i_alpha == '0);
            r_sat  <= (i_chan >= i_alpha);
        end else if (i_step) begin
            r_rem <= fits ? CH_W'(trial - {1'b0, r_den}) : CH_W'(trial);
            r_low <= {r_low[CH_W-2:0], 1'b0};
            r_quo <= {r_quo[CH_W-2:0], fits};
        end
    end

    assign o_value = r_zero ? '0 : (r_sat ? t_chan'(CH_MAX) : r_quo);

endmodule

@@ rtl/cfm_cell.sv @@
// One tap cell of the transposed convolution chain: adds its weighted pixel
// to the partial sums handed in by its neighbor. Uses cfm_pkg.
module cfm_cell import cfm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [WT_W-1:0] i_weight,
    input  t_rgb                   i_px,
    input  t_acc                   i_acc,
    output t_acc                   o_acc
);

    t_acc r_acc;
    t_acc n_acc;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_acc[c] = SUM_W'($signed(i_acc[c]) + i_weight * $signed({1'b0, i_px[c]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

@@ rtl/conv5x5_mirror_rgb_filter.sv @@
// Top level: 5x5 mirrored-border RGBA convolution with un-premultiply.
// A pixel request runs the 8-step divide and the line write; if it emits, the result
// then takes the 25 window reads, the chain drain and the scaling. New requests stall
// until the last one is done; the pace is set by the divider and the single line store
// read port; a flush that emits runs only the reads, drain and scaling. A stalled output
// holds the emit step. Sync active-low reset clears counters, sets 640x480 box mode.
module conv5x5_mirror_rgb_filter import cfm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [CH_W-1:0]       i_in_red,
    input  logic [CH_W-1:0]       i_in_green,
    input  logic [CH_W-1:0]       i_in_blue,
    input  logic [CH_W-1:0]       i_in_alpha,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CH_W-1:0]       o_out_red,
    output logic [CH_W-1:0]       o_out_green,
    output logic [CH_W-1:0]       o_out_blue,
    output logic [CH_W-1:0]       o_out_alpha,
    output logic                  o_frame_last
);

    localparam int RS = HEIGHT_W + 2;
    localparam int CS = WIDTH_W + 2;

    t_state               r_state, n_state;
    logic [WIDTH_W-1:0]   r_width;
    logic [HEIGHT_W-1:0]  r_height;
    logic [MODE_W-1:0]    r_mode;
    logic [COL_W-1:0]     r_in_col, r_out_col;
    logic [ROW_W-1:0]     r_in_row, r_out_row;
    logic [RING_W-1:0]    r_in_ring, r_out_ring;
    logic [IDX_W-1:0]     r_in_idx;
    logic [PEND_W-1:0]    r_pend;
    logic [DCNT_W-1:0]    r_dcnt;
    logic [TAP_W-1:0]     r_dxi, r_dyi;
    logic                 r_feed;
    logic                 r_ctr_rd;
    logic                 r_out_valid;
    t_chan                r_alpha_in;
    t_chan                r_ctr_alpha;
    logic [PIX_W-1:0]     r_rd_data;
    t_chan                r_out_r, r_out_g, r_out_b, r_out_a;
    logic                 r_out_last;
    logic [PIX_W-1:0]     mem [2**ADDR_W];

    logic                 in_acc, cfg_acc, out_free, flush_ok, emit_px, last_tap;
    logic                 lane_load, lane_step;
    t_rgb                 lane_val;
    t_rgb                 feed_px;
    t_acc                 acc_link [TAPS+1];
    logic [WIDTH_W-1:0]   in_col_nx, out_col_nx;
    logic [HEIGHT_W-1:0]  in_row_nx, out_row_nx;
    logic [CFG_WID_W-1:0] cfg_w;
    logic [CFG_HGT_W-1:0] cfg_h;
    logic signed [RS-1:0] row_p, row_a, row_m, row_rel;
    logic signed [CS-1:0] col_p, col_a, col_m;
    logic [RING_W-1:0]    rd_slot;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 frame_last;

    function automatic t_chan scale(input t_sum s, input logic [MODE_W-1:0] mode);
        logic [SUM_W-2:0]         pos;
        logic [SUM_W+RECIP_W-2:0] prod;
        logic [SUM_W-2:0]         q;
        pos = s[SUM_W-2:0];
        case (mode_eff(mode))
            MODE_BOX: begin
                prod = (SUM_W+RECIP_W-1)'(pos) * (SUM_W+RECIP_W-1)'(RECIP25);
                q    = (SUM_W-1)'(prod >> SHIFT25);
            end
            MODE_BART: begin
                prod = (SUM_W+RECIP_W-1)'(pos) * (SUM_W+RECIP_W-1)'(RECIP81);
                q    = (SUM_W-1)'(prod >> SHIFT81);
            end
            default: begin
                prod = '0;
                q    = pos >> GAUSS_SHIFT;
            end
        endcase
        if (s[SUM_W-1] || s == '0) begin
            return '0;
        end else if (q > (SUM_W-1)'(CH_MAX)) begin
            return t_chan'(CH_MAX);
        end
        return t_chan'(q);
    endfunction

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign flush_ok    = (r_pend != '0) && (IDX_W'(r_pend) > r_in_idx);
    assign emit_px     = ((PEND_W+1)'(r_pend) + 1'b1) > ((PEND_W+1)'({r_width, 1'b0}) + 2'd2);
    assign last_tap    = (r_dxi == TAP_W'(KERNEL_N-1)) && (r_dyi == TAP_W'(KERNEL_N-1));
    assign lane_load   = in_acc && (i_action == ACT_PIXEL);
    assign lane_step   = (r_state == ST_DIV);
    assign cfg_w       = i_cfg_data[CFG_WID_W-1:0];
    assign cfg_h       = i_cfg_data[CFG_HGT_W-1:0];

    assign in_col_nx   = WIDTH_W'(r_in_col) + 1'b1;
    assign in_row_nx   = HEIGHT_W'(r_in_row) + 1'b1;
    assign out_col_nx  = WIDTH_W'(r_out_col) + 1'b1;
    assign out_row_nx  = HEIGHT_W'(r_out_row) + 1'b1;
    assign frame_last  = (out_col_nx == r_width) && (out_row_nx == r_height);

    cfm_unpremul u_lane_r (.i_clk(i_clk), .i_load(lane_load), .i_step(lane_step),
                           .i_chan(i_in_red), .i_alpha(i_in_alpha), .o_value(lane_val[0]));
    cfm_unpremul u_lane_g (.i_clk(i_clk), .i_load(lane_load), .i_step(lane_step),
                           .i_chan(i_in_green), .i_alpha(i_in_alpha), .o_value(lane_val[1]));
    cfm_unpremul u_lane_b (.i_clk(i_clk), .i_load(lane_load), .i_step(lane_step),
                           .i_chan(i_in_blue), .i_alpha(i_in_alpha), .o_value(lane_val[2]));

    // mirrored window address
    always_comb begin
        row_p   = $signed(RS'(r_out_row)) + $signed(RS'(r_dyi)) - $signed(RS'(KERNEL_N / 2));
        row_a   = row_p[RS-1] ? -row_p : row_p;
        row_m   = (row_a >= $signed(RS'(r_height)))
                ? $signed(RS'({r_height, 1'b0})) - $signed(RS'(2)) - row_a : row_a;
        row_rel = row_m - $signed(RS'(r_out_row));
        rd_slot = r_out_ring + row_rel[RING_W-1:0];
        col_p   = $signed(CS'(r_out_col)) + $signed(CS'(r_dxi)) - $signed(CS'(KERNEL_N / 2));
        col_a   = col_p[CS-1] ? -col_p : col_p;
        col_m   = (col_a >= $signed(CS'(r_width)))
                ? $signed(CS'({r_width, 1'b0})) - $signed(CS'(2)) - col_a : col_a;
        rd_addr = {rd_slot, col_m[COL_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            mem[{r_in_ring, r_in_col}] <= {r_alpha_in, lane_val[2], lane_val[1], lane_val[0]};
        end
        r_rd_data <= mem[rd_addr];
    end

    assign feed_px[0]     = r_rd_data[CH_W-1:0];
    assign feed_px[1]     = r_rd_data[2*CH_W-1:CH_W];
    assign feed_px[2]     = r_rd_data[3*CH_W-1:2*CH_W];
    assign acc_link[TAPS] = '0;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        localparam int TAP_ROW = (TAPS - 1 - k) / KERNEL_N;
        localparam int TAP_COL = (TAPS - 1 - k) % KERNEL_N;
        cfm_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (r_feed),
            .i_weight(kernel_weight(r_mode, TAP_ROW, TAP_COL)),
            .i_px    (feed_px),
            .i_acc   (acc_link[k+1]),
            .o_acc   (acc_link[k])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_action == ACT_PIXEL) begin
                        n_state = ST_DIV;
                    end else if (flush_ok) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_DIV: begin
                if (r_dcnt == DCNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: n_state = emit_px ? ST_READ : ST_IDLE;
            ST_READ: begin
                if (last_tap) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM:  n_state = ST_QUOT;
            ST_QUOT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width     <= WIDTH_W'(640);
            r_height    <= HEIGHT_W'(480);
            r_mode      <= MODE_BOX;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_in_ring   <= '0;
            r_in_idx    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_ring  <= '0;
            r_pend      <= '0;
            r_dcnt      <= '0;
            r_dxi       <= '0;
            r_dyi       <= '0;
            r_feed      <= 1'b0;
            r_ctr_rd    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_feed   <= (r_state == ST_READ);
            r_ctr_rd <= (r_state == ST_READ) && (r_dxi == TAP_W'(KERNEL_N / 2))
                        && (r_dyi == TAP_W'(KERNEL_N / 2));
            r_out_valid <= ((r_state == ST_QUOT) && out_free) ? 1'b1
                         : (r_out_valid && i_out_stall);
            if (cfg_acc) begin
                case (i_cfg_index)
                    CFG_WIDTH: begin
                        if (cfg_w < CFG_WID_W'(3)) begin
                            r_width <= WIDTH_W'(3);
                        end else if (cfg_w > CFG_WID_W'(MAX_WIDTH)) begin
                            r_width <= WIDTH_W'(MAX_WIDTH);
                        end else begin
                            r_width <= WIDTH_W'(cfg_w);
                        end
                    end
                    CFG_HEIGHT: begin
                        if (cfg_h < CFG_HGT_W'(3)) begin
                            r_height <= HEIGHT_W'(3);
                        end else if (cfg_h > CFG_HGT_W'(MAX_HEIGHT)) begin
                            r_height <= HEIGHT_W'(MAX_HEIGHT);
                        end else begin
                            r_height <= HEIGHT_W'(cfg_h);
                        end
                    end
                    CFG_MODE: r_mode <= i_cfg_data[MODE_W-1:0];
                    default: ;
                endcase
                if (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT) begin
                    r_in_col   <= '0;
                    r_in_row   <= '0;
                    r_in_ring  <= '0;
                    r_in_idx   <= '0;
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                    r_out_ring <= '0;
                    r_pend     <= '0;
                end
            end
            case (r_state)
                ST_IDLE: begin
                    r_dcnt <= '0;
                    r_dxi  <= '0;
                    r_dyi  <= '0;
                end
                ST_DIV: r_dcnt <= r_dcnt + 1'b1;
                ST_WRITE: begin
                    r_pend <= r_pend + 1'b1;
                    r_dxi  <= '0;
                    r_dyi  <= '0;
                    if (in_col_nx >= r_width) begin
                        r_in_col  <= '0;
                        r_in_ring <= r_in_ring + 1'b1;
                        if (in_row_nx >= r_height) begin
                            r_in_row <= '0;
                            r_in_idx <= '0;
                        end else begin
                            r_in_row <= ROW_W'(in_row_nx);
                            r_in_idx <= r_in_idx + 1'b1;
                        end
                    end else begin
                        r_in_col <= COL_W'(in_col_nx);
                        r_in_idx <= r_in_idx + 1'b1;
                    end
                end
                ST_READ: begin
                    if (r_dxi == TAP_W'(KERNEL_N - 1)) begin
                        r_dxi <= '0;
                        r_dyi <= r_dyi + 1'b1;
                    end else begin
                        r_dxi <= r_dxi + 1'b1;
                    end
                end
                ST_QUOT: begin
                    if (out_free) begin
                        r_pend <= r_pend - 1'b1;
                        if (out_col_nx >= r_width) begin
                            r_out_col  <= '0;
                            r_out_ring <= r_out_ring + 1'b1;
                            r_out_row  <= (out_row_nx >= r_height) ? '0 : ROW_W'(out_row_nx);
                        end else begin
                            r_out_col <= COL_W'(out_col_nx);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (lane_load) begin
            r_alpha_in <= i_in_alpha;
        end
        if (r_ctr_rd) begin
            r_ctr_alpha <= r_rd_data[PIX_W-1:3*CH_W];
        end
        if (r_state == ST_QUOT && out_free) begin
            r_out_r    <= scale(acc_link[0][0], r_mode);
            r_out_g    <= scale(acc_link[0][1], r_mode);
            r_out_b    <= scale(acc_link[0][2], r_mode);
            r_out_a    <= r_ctr_alpha;
            r_out_last <= frame_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_red    = r_out_r;
    assign o_out_green  = r_out_g;
    assign o_out_blue   = r_out_b;
    assign o_out_alpha  = r_out_a;
    assign o_frame_last = r_out_last;

endmodule

@@ tb/tb.sv @@
// Testbench for conv5x5_mirror_rgb_filter: directed and random RGBA streams,
// checked per field against an in-bench 5x5 mirrored convolution predictor.
// Depends on rtl/cfm_pkg.sv and rtl/conv5x5_mirror_rgb_filter.sv.
`timescale 1ns / 100ps

module tb;
    import cfm_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int ITEM_TARGET = 1900;
    localparam int SETTLE      = 60;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic [7:0] r, g, b, a;
        logic       fl;
    } t_pix;

    typedef struct {
        logic       act;
        logic [7:0] r, g, b, a;
        bit         typed;
        t_pix       want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_action = ACT_PIXEL;
    logic [CH_W-1:0]       i_in_red = '0, i_in_green = '0, i_in_blue = '0, i_in_alpha = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [CH_W-1:0]       o_out_red, o_out_green, o_out_blue, o_out_alpha;
    logic                  o_frame_last;

    conv5x5_mirror_rgb_filter u_top (.*);

    // filter state mirror
    logic [31:0] ring_px [0:RING_ROWS*MAX_WIDTH-1];
    int unsigned img_w, img_h, kmode;
    int unsigned icol, irow, ocol, orow, pend, iring, oring;

    t_pix        want_px[$];
    t_row        rows[$];
    int          n_err = 0;
    int          n_items = 0;
    int unsigned cyc = 0;
    int          hold_left = 0;
    int          hold_seq = 0;
    int          hold_seen = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int exp);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, exp, cyc);
        n_err++;
    endtask

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [7:0] unpremul(input int unsigned c, input int unsigned a);
        int unsigned v;
        if (a == 0) return 8'd0;
        v = c * 255 / a;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic int mirror(input int p, input int n);
        if (p < 0) p = -p;
        if (p >= n) p = 2 * n - 2 - p;
        return p;
    endfunction

    function automatic int tap(input int unsigned m, input int i);
        int bart[5] = '{1, 2, 3, 2, 1};
        int gaus[5] = '{1, 4, 6, 4, 1};
        if (m == MODE_BOX) return 1;
        if (m == MODE_BART) return bart[i];
        return gaus[i];
    endfunction

    function automatic void restart_stream();
        icol = 0; irow = 0; ocol = 0; orow = 0; pend = 0; iring = 0; oring = 0;
    endfunction

    function automatic void add_row(input logic act, input logic [7:0] r, g, b, a,
                                    input bit typed, input t_pix want);
        t_row e;
        e.act   = act;
        e.r     = r;
        e.g     = g;
        e.b     = b;
        e.a     = a;
        e.typed = typed;
        e.want  = want;
        rows.insert(rows.size(), e);
    endfunction

    function automatic t_pix convolve_next();
        int          sum[3];
        int          dv, rr, cc, wt, r0, c0;
        int unsigned m, slot;
        logic [31:0] px, ctr;
        t_pix        o;
        m  = (kmode > MODE_ENHANCE) ? MODE_BOX : kmode;
        dv = (m == MODE_BOX) ? 25 : (m == MODE_BART) ? 81 : 256;
        r0 = orow; c0 = ocol;
        sum = '{0, 0, 0};
        ctr = '0;
        for (int dy = -2; dy <= 2; dy++) begin
            rr   = mirror(r0 + dy, img_h);
            slot = (oring + RING_ROWS + (rr - r0)) % RING_ROWS;
            for (int dx = -2; dx <= 2; dx++) begin
                cc = mirror(c0 + dx, img_w);
                px = ring_px[slot * MAX_WIDTH + cc];
                wt = tap(m, dy + 2) * tap(m, dx + 2);
                if (m >= MODE_EDGE) begin
                    wt = -wt;
                    if (dy == 0 && dx == 0) wt = (m == MODE_EDGE) ? EDGE_CTR : ENH_CTR;
                end
                if (dy == 0 && dx == 0) ctr = px;
                for (int ch = 0; ch < 3; ch++) sum[ch] += wt * int'(px[8*ch +: 8]);
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = (sum[ch] > 0) ? sum[ch] / dv : 0;
            if (sum[ch] > 255) sum[ch] = 255;
        end
        o.r  = sum[0][7:0];
        o.g  = sum[1][7:0];
        o.b  = sum[2][7:0];
        o.a  = ctr[31:24];
        o.fl = (orow == img_h - 1 && ocol == img_w - 1);
        ocol++;
        if (ocol >= img_w) begin
            ocol = 0;
            oring = (oring + 1) % RING_ROWS;
            orow++;
            if (orow >= img_h) orow = 0;
        end
        pend--;
        return o;
    endfunction

    // returns 1 when the request yields an output pixel
    function automatic bit absorb_request(input logic act, input logic [7:0] r, g, b, a,
                                          output t_pix o);
        logic [31:0] w;
        if (act == ACT_FLUSH) begin
            if (pend > 0 && pend > irow * img_w + icol) begin
                o = convolve_next();
                return 1;
            end
            return 0;
        end
        w = {a, unpremul(b, a), unpremul(g, a), unpremul(r, a)};
        ring_px[iring * MAX_WIDTH + icol] = w;
        icol++;
        if (icol >= img_w) begin
            icol = 0;
            iring = (iring + 1) % RING_ROWS;
            irow++;
            if (irow >= img_h) irow = 0;
        end
        pend++;
        if (pend > 2 * img_w + 2) begin
            o = convolve_next();
            return 1;
        end
        return 0;
    endfunction

    function automatic int pick_gap();
        int p;
        if (cyc[11]) return 0;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    task automatic send(input logic act, input logic [7:0] r, g, b, a,
                        input bit typed, input t_pix typed_px);
        t_pix o;
        int   gap;
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_in_red   <= r;
        i_in_green <= g;
        i_in_blue  <= b;
        i_in_alpha <= a;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (absorb_request(act, r, g, b, a, o)) begin
            want_px.insert(want_px.size(), typed ? typed_px : o);
        end
        n_items++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_px(input logic act, input logic [7:0] r, g, b, a);
        t_pix none;
        none = '{default: '0};
        send(act, r, g, b, a, 1'b0, none);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (want_px.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH) begin
            img_w = clamp_dim(d[11:0], MAX_WIDTH);
            restart_stream();
        end else if (idx == CFG_HEIGHT) begin
            img_h = clamp_dim(d, MAX_HEIGHT);
            restart_stream();
        end else if (idx == CFG_MODE) begin
            kmode = d[2:0];
        end
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_alpha();
        int p;
        p = $urandom_range(0, 7);
        if (p == 0) return 8'd0;
        if (p == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic rand_pixel();
        send_px(ACT_PIXEL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), rand_alpha());
    endtask

    // receiver: check and stall
    always @(posedge i_clk) begin
        t_pix e;
        int   p;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (want_px.size() == 0) begin
                report("unexpected output", o_out_red, -1);
            end else begin
                e = want_px.pop_front();
                if (o_out_red !== e.r) report("red", o_out_red, e.r);
                if (o_out_green !== e.g) report("green", o_out_green, e.g);
                if (o_out_blue !== e.b) report("blue", o_out_blue, e.b);
                if (o_out_alpha !== e.a) report("alpha", o_out_alpha, e.a);
                if (o_frame_last !== e.fl) report("frame_last", o_frame_last, e.fl);
            end
        end
        if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= 400;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (cyc[12]) begin
            i_out_stall <= 1'b0;
        end else begin
            p = $urandom_range(0, 99);
            if (p < 60) begin
                i_out_stall <= 1'b0;
            end else if (p < 96) begin
                i_out_stall <= 1'b1;
                hold_left <= $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                hold_left <= $urandom_range(20, 60);
            end
        end
    end

    initial begin
        t_pix full, none;
        int   w, h, phase, frames;
        for (int i = 0; i < RING_ROWS * MAX_WIDTH; i++) ring_px[i] = '0;
        img_w = 640; img_h = 480; kmode = MODE_BOX;
        restart_stream();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 3x3 opaque white frame, drain, then extremes of the fields
        cfg_write(CFG_WIDTH, 13'd3);
        cfg_write(CFG_HEIGHT, 13'd3);
        cfg_write(CFG_MODE, CFG_DATA_W'(MODE_BOX));
        full = '{r: 8'd255, g: 8'd255, b: 8'd255, a: 8'd255, fl: 1'b0};
        none = '{default: '0};
        for (int i = 0; i < 9; i++) add_row(ACT_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 1, full);
        for (int i = 0; i < 8; i++) begin
            full.fl = (i == 7);
            add_row(ACT_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1, full);
        end
        add_row(ACT_FLUSH, 8'd255, 8'd255, 8'd255, 8'd255, 0, none);
        add_row(ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 0, none);
        add_row(ACT_PIXEL, 8'd255, 8'd255, 8'd255, 8'd0, 0, none);
        add_row(ACT_PIXEL, 8'd200, 8'd10, 8'd0, 8'd100, 0, none);
        add_row(ACT_PIXEL, 8'd255, 8'd0, 8'd255, 8'd128, 0, none);
        add_row(ACT_PIXEL, 8'd1, 8'd1, 8'd1, 8'd1, 0, none);
        add_row(ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd255, 0, none);
        add_row(ACT_PIXEL, 8'd170, 8'd85, 8'd254, 8'd254, 0, none);
        foreach (rows[i]) send(rows[i].act, rows[i].r, rows[i].g, rows[i].b, rows[i].a,
                               rows[i].typed, rows[i].want);

        // random phases over geometry and kernel mode
        phase = 0;
        while (n_items < ITEM_TARGET) begin
            wait_drained();
            phase++;
            if (phase == 1) begin
                cfg_write(CFG_WIDTH, 13'd4095);
                cfg_write(CFG_HEIGHT, 13'd8191);
                cfg_write(CFG_MODE, 13'd7);
                for (int i = 0; i < 30; i++) rand_pixel();
                continue;
            end
            if (phase == 4) begin
                cfg_write(CFG_HEIGHT, 13'd0);
                cfg_write(CFG_WIDTH, 13'd0);
            end else if (phase == 6) begin
                cfg_write(CFG_WIDTH, 13'd2);
                cfg_write(CFG_HEIGHT, 13'd1);
            end else begin
                w = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(3, 12);
                h = $urandom_range(3, 6);
                if ($urandom_range(0, 1)) begin
                    cfg_write(CFG_WIDTH, CFG_DATA_W'(w));
                    cfg_write(CFG_HEIGHT, CFG_DATA_W'(h));
                end else begin
                    cfg_write(CFG_HEIGHT, CFG_DATA_W'(h));
                    cfg_write(CFG_WIDTH, CFG_DATA_W'(w));
                end
            end
            if (phase == 7) cfg_write(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 8191)));
            cfg_write(CFG_MODE, CFG_DATA_W'(phase % 8));
            if (phase == 2) hold_seq++;
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                for (int i = 0; i < img_w * img_h; i++) begin
                    if ($urandom_range(0, 24) == 0) begin
                        send_px(ACT_FLUSH, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
                    end
                    if (phase == 3 && f == 0 && i == img_w * 2 + 5) wait_drained();
                    rand_pixel();
                end
            end
            // usually drain the tail; now and then restart mid-stream instead
            if ($urandom_range(0, 7) != 0) begin
                for (int i = 0; i < 2 * img_w + 4; i++) send_px(ACT_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0);
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (n_err == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

@@ conv5x5_mirror_rgb_filter.f @@
rtl/cfm_pkg.sv
rtl/cfm_unpremul.sv
rtl/cfm_cell.sv
rtl/conv5x5_mirror_rgb_filter.sv
tb/tb.sv
